/* rtl/nco_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_pkg: shared types and constants of the AM/PM/FM modulator
// Register map, reset values, mode codes and the structs that pass between
// the front end, the sample queue, the back-end sequencer and the sine ROM.
// ----------------------------------------------------------------------------
package nco_pkg;

	// default sizes of the sine table and of its samples
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	// phase accumulators and sample queue
	localparam int PHASE_W    = 32;
	localparam int FIFO_DEPTH = 4;
	localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

	// configuration port
	localparam int PADDR_W = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_CARRIER_STEP = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MESSAGE_STEP = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODE         = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_AM_GAIN      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PM_INDEX     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FM_INDEX     = 3'd5;

	// register reset values
	localparam logic [31:0] CARRIER_STEP_RST = 32'd171798692;
	localparam logic [31:0] MESSAGE_STEP_RST = 32'd17179869;
	localparam logic [1:0]  MODE_RST         = 2'd0;
	localparam logic [15:0] AM_GAIN_RST      = 16'd16384;
	localparam logic [19:0] PM_INDEX_RST     = 20'd98304;
	localparam logic [19:0] FM_INDEX_RST     = 20'd78230;

	// modulation modes; the fourth code gives a zero modulated sample
	localparam logic [1:0] MODE_AM = 2'd0;
	localparam logic [1:0] MODE_PM = 2'd1;
	localparam logic [1:0] MODE_FM = 2'd2;

	// phase pair handed from the front end to the back end
	typedef struct packed {
		logic [PHASE_W-1:0] carrier;
		logic [PHASE_W-1:0] message;
	} phase_pair_t;

	// modulation settings seen by the back end
	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] am_gain;
		logic [19:0] pm_index;
		logic [19:0] fm_index;
	} cfg_t;

	// queue status
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	// sine ROM read enables
	typedef struct packed {
		logic en_a;
		logic en_b;
	} rom_en_t;

	// back-end sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CONV,
		ST_MUL1,
		ST_MUL2,
		ST_FIN
	} back_state_t;

endpackage

/* rtl/nco_am_pm_fm_modulator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_am_pm_fm_modulator_core: DDS sample modulator, AM / PM / FM
// Two phase accumulators and a quarter-wave sine ROM producing one
// modulated sample and its message sample per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, restart): one request per sample tick.
//   restart = 1 zeroes both accumulators before the sample is formed.
//   Output channel (out_valid/out_ready): modulated (Q4.15, saturated) and
//   message (Q1.15), one result per request, in request order.
//   APB port: carrier_step, message_step, mode, am_gain, pm_index, fm_index
//   at byte addresses 0x00..0x14; write only while the block is idle.
//   Path: the queue, then back-end sequencer states READ, CONV, MUL1, MUL2
//   and FIN; the result is registered at the end. A new sample starts only
//   after FIN of the last one, since the PM/FM carrier lookup needs the
//   message sample from the same ROM read path first. The front end takes
//   requests every cycle until the 4-entry queue fills.
//   Reset: accumulators zero, registers at their defaults, queue empty.
//   Receiver stall: the sample holds in the output register, the sequencer
//   waits, the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
module nco_am_pm_fm_modulator_core #(
	parameter int TABLE_ADDR_BITS = nco_pkg::TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS     = nco_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nco_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        restart,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [18:0]          modulated,
	output logic signed [15:0]          message
);

	logic [31:0] carrier_step_q;
	logic [31:0] message_step_q;
	logic [1:0]  mode_q;
	logic [15:0] am_gain_q;
	logic [19:0] pm_index_q;
	logic [19:0] fm_index_q;

	logic [nco_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          reg_wr;

	nco_pkg::cfg_t        cfg;
	nco_pkg::phase_pair_t push_item, pop_item;
	nco_pkg::fifo_stat_t  fifo_stat;
	nco_pkg::rom_en_t     rom_en;
	logic push, pop;
	logic [nco_pkg::PHASE_W-1:0] rom_phase_a, rom_phase_b;
	logic [SAMPLE_BITS-2:0] rom_mag_a, rom_mag_b;
	logic rom_neg_a, rom_neg_b;

	// register decode
	assign pready  = 1'b1;
	assign reg_idx = paddr[nco_pkg::PADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_step_q <= nco_pkg::CARRIER_STEP_RST;
			message_step_q <= nco_pkg::MESSAGE_STEP_RST;
			mode_q         <= nco_pkg::MODE_RST;
			am_gain_q      <= nco_pkg::AM_GAIN_RST;
			pm_index_q     <= nco_pkg::PM_INDEX_RST;
			fm_index_q     <= nco_pkg::FM_INDEX_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				nco_pkg::REG_CARRIER_STEP: carrier_step_q <= pwdata;
				nco_pkg::REG_MESSAGE_STEP: message_step_q <= pwdata;
				nco_pkg::REG_MODE:         mode_q         <= pwdata[1:0];
				nco_pkg::REG_AM_GAIN:      am_gain_q      <= pwdata[15:0];
				nco_pkg::REG_PM_INDEX:     pm_index_q     <= pwdata[19:0];
				nco_pkg::REG_FM_INDEX:     fm_index_q     <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			nco_pkg::REG_CARRIER_STEP: prdata = carrier_step_q;
			nco_pkg::REG_MESSAGE_STEP: prdata = message_step_q;
			nco_pkg::REG_MODE:         prdata = {30'd0, mode_q};
			nco_pkg::REG_AM_GAIN:      prdata = {16'd0, am_gain_q};
			nco_pkg::REG_PM_INDEX:     prdata = {12'd0, pm_index_q};
			nco_pkg::REG_FM_INDEX:     prdata = {12'd0, fm_index_q};
			default:                   prdata = '0;
		endcase
	end

	assign cfg.mode     = mode_q;
	assign cfg.am_gain  = am_gain_q;
	assign cfg.pm_index = pm_index_q;
	assign cfg.fm_index = fm_index_q;

	nco_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.carrier_step (carrier_step_q),
		.message_step (message_step_q),
		.fifo_stat    (fifo_stat),
		.push         (push),
		.item         (push_item)
	);

	nco_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.pop     (pop),
		.rd_item (pop_item),
		.stat    (fifo_stat)
	);

	nco_rom #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_rom (
		.clk     (clk),
		.en      (rom_en),
		.phase_a (rom_phase_a),
		.phase_b (rom_phase_b),
		.mag_a   (rom_mag_a),
		.neg_a   (rom_neg_a),
		.mag_b   (rom_mag_b),
		.neg_b   (rom_neg_b)
	);

	nco_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item        (pop_item),
		.fifo_stat   (fifo_stat),
		.pop         (pop),
		.rom_en      (rom_en),
		.rom_phase_a (rom_phase_a),
		.rom_phase_b (rom_phase_b),
		.rom_mag_a   (rom_mag_a),
		.rom_neg_a   (rom_neg_a),
		.rom_mag_b   (rom_mag_b),
		.rom_neg_b   (rom_neg_b),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.modulated   (modulated),
		.message     (message)
	);

	// results stay inside their symmetric ranges
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (message != 16'sh8000) && (modulated != 19'sh40000))
		else $error("result outside symmetric range");

	// queue status is consistent
	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_stat.full && fifo_stat.empty))
		else $error("queue reports full and empty");

	// sequencer never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty)
		else $error("pop from empty queue");

	// a full queue stays full until the sequencer pops an entry
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.full && !pop |=> fifo_stat.full)
		else $error("full queue lost an entry without a pop");

endmodule

/* rtl/nco_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_rom: quarter-wave sine ROM with two registered read ports
// Each port takes a 32-bit phase, folds it into the first quadrant and
// returns the table magnitude together with the sign of the half turn.
// ----------------------------------------------------------------------------
module nco_rom #(
	parameter int TABLE_ADDR_BITS = nco_pkg::TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS     = nco_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  nco_pkg::rom_en_t             en,
	input  logic [nco_pkg::PHASE_W-1:0]  phase_a,
	input  logic [nco_pkg::PHASE_W-1:0]  phase_b,
	output logic [SAMPLE_BITS-2:0]       mag_a,
	output logic                         neg_a,
	output logic [SAMPLE_BITS-2:0]       mag_b,
	output logic                         neg_b
);

	localparam int QSIZE = 1 << (TABLE_ADDR_BITS - 2);
	localparam int QA    = TABLE_ADDR_BITS - 1;
	localparam logic [63:0] AMP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

	// Taylor coefficients of sin(pi/2*z), Q30
	localparam logic [63:0] C1 = 64'd1686629713;
	localparam logic [63:0] C3 = 64'd693598668;
	localparam logic [63:0] C5 = 64'd85569306;
	localparam logic [63:0] C7 = 64'd5026995;
	localparam logic [63:0] C9 = 64'd172272;

	typedef logic [SAMPLE_BITS-2:0] sine_tab_t [0:QSIZE];

	// table built at elaboration, Horner in Q30 with truncating shifts
	function automatic sine_tab_t build_tab();
		sine_tab_t t;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] r;
		logic [63:0] v;
		for (int k = 0; k <= QSIZE; k++) begin
			z  = 64'(k) << (30 - (TABLE_ADDR_BITS - 2));
			z2 = (z * z) >> 30;
			r  = C9;
			r  = C7 - ((z2 * r) >> 30);
			r  = C5 - ((z2 * r) >> 30);
			r  = C3 - ((z2 * r) >> 30);
			r  = C1 - ((z2 * r) >> 30);
			r  = (z * r) >> 30;
			v  = (r * AMP + (64'd1 << 29)) >> 30;
			if (v > AMP) begin
				v = AMP;
			end
			t[k] = v[SAMPLE_BITS-2:0];
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_tab();

	// fold a phase into a first-quadrant table address
	function automatic logic [QA-1:0] tab_addr(input logic [nco_pkg::PHASE_W-1:0] ph);
		logic [TABLE_ADDR_BITS-1:0] idx;
		logic [TABLE_ADDR_BITS-3:0] k;
		idx = ph[nco_pkg::PHASE_W-1 -: TABLE_ADDR_BITS];
		k   = idx[TABLE_ADDR_BITS-3:0];
		if (idx[TABLE_ADDR_BITS-2]) begin
			return QA'(QSIZE) - {1'b0, k};
		end
		return {1'b0, k};
	endfunction

	// registered reads; outputs hold while a port is not enabled
	always_ff @(posedge clk) begin
		if (en.en_a) begin
			mag_a <= SINE_TAB[tab_addr(phase_a)];
			neg_a <= phase_a[nco_pkg::PHASE_W-1];
		end
		if (en.en_b) begin
			mag_b <= SINE_TAB[tab_addr(phase_b)];
			neg_b <= phase_b[nco_pkg::PHASE_W-1];
		end
	end

endmodule

/* rtl/nco_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_fifo: short queue of phase pairs between front end and back end
// Register-based FIFO with first-word fall-through read.
// ----------------------------------------------------------------------------
module nco_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nco_pkg::phase_pair_t wr_item,
	input  logic                 pop,
	output nco_pkg::phase_pair_t rd_item,
	output nco_pkg::fifo_stat_t  stat
);

	localparam int DEPTH = nco_pkg::FIFO_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	nco_pkg::phase_pair_t mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));
	assign rd_item    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/nco_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_front: request intake and phase accumulators
// Takes one request per cycle while the queue has room, applies restart and
// queues the phases for this sample, then advances both accumulators.
// ----------------------------------------------------------------------------
module nco_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        restart,
	input  logic [nco_pkg::PHASE_W-1:0] carrier_step,
	input  logic [nco_pkg::PHASE_W-1:0] message_step,
	input  nco_pkg::fifo_stat_t         fifo_stat,
	output logic                        push,
	output nco_pkg::phase_pair_t        item
);

	logic [nco_pkg::PHASE_W-1:0] carrier_q;
	logic [nco_pkg::PHASE_W-1:0] message_q;

	assign in_ready = !fifo_stat.full;
	assign push     = in_valid && in_ready;

	// phases used by this sample
	assign item.carrier = restart ? '0 : carrier_q;
	assign item.message = restart ? '0 : message_q;

	// accumulators advance once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= '0;
			message_q <= '0;
		end else if (push) begin
			carrier_q <= item.carrier + carrier_step;
			message_q <= item.message + message_step;
		end
	end

endmodule

/* rtl/nco_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nco_back: modulation sequencer
// Pops a phase pair, reads message and carrier from the sine ROM, forms the
// AM product or the PM/FM phase offset and a second carrier read, then
// rounds, saturates and holds the sample in the output register.
// ----------------------------------------------------------------------------
module nco_back #(
	parameter int SAMPLE_BITS = nco_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nco_pkg::cfg_t               cfg,
	input  nco_pkg::phase_pair_t        item,
	input  nco_pkg::fifo_stat_t         fifo_stat,
	output logic                        pop,
	output nco_pkg::rom_en_t            rom_en,
	output logic [nco_pkg::PHASE_W-1:0] rom_phase_a,
	output logic [nco_pkg::PHASE_W-1:0] rom_phase_b,
	input  logic [SAMPLE_BITS-2:0]      rom_mag_a,
	input  logic                        rom_neg_a,
	input  logic [SAMPLE_BITS-2:0]      rom_mag_b,
	input  logic                        rom_neg_b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [18:0]          modulated,
	output logic signed [15:0]          message
);

	localparam int RSH = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
	localparam int LSH = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
	localparam logic [24:0] HALF = 25'((1 << RSH) >> 1);

	// table magnitude to Q1.15 magnitude, rounded half up and clamped
	function automatic logic [14:0] q15(input logic [SAMPLE_BITS-2:0] mag);
		logic [24:0] t;
		t = 25'(mag);
		t = ((t + HALF) >> RSH) << LSH;
		return (t > 25'd32767) ? 15'h7FFF : t[14:0];
	endfunction

	nco_pkg::back_state_t state_q, state_d;

	logic [nco_pkg::PHASE_W-1:0] cph_q;
	logic [nco_pkg::PHASE_W-1:0] mph_q;
	logic signed [15:0] m_q;
	logic signed [15:0] c_q;
	logic [31:0] prod1_q;
	logic [30:0] off_q;
	logic signed [48:0] p_q;
	logic out_valid_q;
	logic signed [18:0] modulated_q;
	logic signed [15:0] message_q;
	logic load_out;

	logic [15:0] m_mag, c_mag, m_off;
	logic [19:0] idx_sel;
	logic signed [20:0] idx_sx;
	logic signed [36:0] pm_prod;
	logic signed [32:0] prod1_sx;
	logic signed [48:0] am_prod;
	logic [47:0] p_mag;
	logic [48:0] p_rnd;
	logic [19:0] am_mag;
	logic [18:0] am_sat;
	logic signed [18:0] am_res;
	logic [15:0] pm_mag;
	logic signed [18:0] pm_res;
	logic signed [18:0] mod_res;

	assign out_valid = out_valid_q;
	assign modulated = modulated_q;
	assign message   = message_q;

	// sine samples brought to Q1.15 magnitudes
	assign m_mag = {1'b0, q15(rom_mag_a)};
	assign c_mag = {1'b0, q15(rom_mag_b)};

	// AM: m + 32768 as an unsigned word, then times the carrier
	assign m_off    = {~m_q[15], m_q[14:0]};
	assign prod1_sx = {1'b0, prod1_q};
	assign am_prod  = 49'(prod1_sx) * 49'(c_q);

	// PM/FM: index times message, Q.31 turns
	assign idx_sel = (cfg.mode == nco_pkg::MODE_PM) ? cfg.pm_index : cfg.fm_index;
	assign idx_sx  = {1'b0, idx_sel};
	assign pm_prod = 37'(idx_sx) * 37'(m_q);

	// AM rounding to Q4.15 and saturation
	assign p_mag  = p_q[48] ? 48'(-p_q) : 48'(p_q);
	assign p_rnd  = {1'b0, p_mag} + (49'd1 << 28);
	assign am_mag = p_rnd[48:29];
	assign am_sat = (am_mag > 20'd262143) ? 19'd262143 : am_mag[18:0];
	assign am_res = p_q[48] ? -am_sat : am_sat;

	// PM/FM carrier sample
	assign pm_mag = {1'b0, q15(rom_mag_b)};
	assign pm_res = rom_neg_b ? -19'(pm_mag) : 19'(pm_mag);

	// output select by mode
	always_comb begin
		unique case (cfg.mode) inside
			nco_pkg::MODE_AM:                  mod_res = am_res;
			nco_pkg::MODE_PM, nco_pkg::MODE_FM: mod_res = pm_res;
			default:                           mod_res = '0;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nco_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ROM / queue controls
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		load_out    = 1'b0;
		rom_en      = '0;
		rom_phase_a = mph_q;
		rom_phase_b = cph_q + nco_pkg::QUARTER_TURN;
		unique case (state_q)
			nco_pkg::ST_IDLE: begin
				if (!fifo_stat.empty) begin
					pop     = 1'b1;
					state_d = nco_pkg::ST_READ;
				end
			end
			nco_pkg::ST_READ: begin
				rom_en.en_a = 1'b1;
				rom_en.en_b = 1'b1;
				state_d     = nco_pkg::ST_CONV;
			end
			nco_pkg::ST_CONV: begin
				state_d = nco_pkg::ST_MUL1;
			end
			nco_pkg::ST_MUL1: begin
				state_d = nco_pkg::ST_MUL2;
			end
			nco_pkg::ST_MUL2: begin
				// carrier read shifted by the phase offset
				rom_en.en_b = (cfg.mode == nco_pkg::MODE_PM) || (cfg.mode == nco_pkg::MODE_FM);
				rom_phase_b = cph_q + {off_q, 1'b0} + nco_pkg::QUARTER_TURN;
				state_d     = nco_pkg::ST_FIN;
			end
			nco_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					if (!fifo_stat.empty) begin
						pop     = 1'b1;
						state_d = nco_pkg::ST_READ;
					end else begin
						state_d = nco_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = nco_pkg::ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cph_q <= item.carrier;
			mph_q <= item.message;
		end
		if (state_q == nco_pkg::ST_CONV) begin
			m_q <= rom_neg_a ? -m_mag : m_mag;
			c_q <= rom_neg_b ? -c_mag : c_mag;
		end
		if (state_q == nco_pkg::ST_MUL1) begin
			prod1_q <= 32'(cfg.am_gain) * 32'(m_off);
			off_q   <= pm_prod[30:0];
		end
		if (state_q == nco_pkg::ST_MUL2) begin
			p_q <= am_prod;
		end
		if (load_out) begin
			modulated_q <= mod_res;
			message_q   <= m_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* tb/sv/tb_nco_am_pm_fm_modulator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nco_am_pm_fm_modulator_core: self-checking bench for the DDS modulator
// Drives sample-tick requests and APB register writes, predicts every result
// with a bit-true model of the two phase accumulators, the quarter-wave sine
// table and the AM / PM / FM math, and checks results in order under random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb_nco_am_pm_fm_modulator_core;

	localparam int TAB_BITS = nco_pkg::TABLE_ADDR_BITS_DEF;
	localparam int SMP_BITS = nco_pkg::SAMPLE_BITS_DEF;
	localparam int QSIZE    = 1 << (TAB_BITS - 2);
	localparam longint AMP  = (longint'(1) << (SMP_BITS - 1)) - 1;
	localparam int SHIFT_R  = (SMP_BITS > 16) ? SMP_BITS - 16 : 0;
	localparam int SHIFT_L  = (SMP_BITS < 16) ? 16 - SMP_BITS : 0;
	localparam longint MOD_MAX = 262143;

	// Taylor coefficients of sin(pi/2*z), Q30
	localparam longint unsigned POLY_C1 = 64'd1686629713;
	localparam longint unsigned POLY_C3 = 64'd693598668;
	localparam longint unsigned POLY_C5 = 64'd85569306;
	localparam longint unsigned POLY_C7 = 64'd5026995;
	localparam longint unsigned POLY_C9 = 64'd172272;

	// codes not named by the package
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [nco_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [nco_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int TICKS_PER_PHASE = 150;
	localparam int RANDOM_PHASES   = 12;
	localparam int LONG_STALL      = 120;
	localparam int SETTLE_CYCLES   = 10;
	localparam int LIMIT_CYCLES    = 200000;
	localparam int IDLE_PCT        = 19;

	typedef struct packed {
		logic signed [18:0] modulated;
		logic signed [15:0] message;
	} sample_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [nco_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready, restart;
	logic out_valid, out_ready;
	logic signed [18:0] modulated;
	logic signed [15:0] message;

	nco_am_pm_fm_modulator_core #(
		.TABLE_ADDR_BITS(TAB_BITS),
		.SAMPLE_BITS    (SMP_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.modulated(modulated),
		.message  (message)
	);

	// shadow registers and accumulators
	logic [31:0] cfg_carrier_step, cfg_message_step;
	logic [1:0]  cfg_mode;
	logic [15:0] cfg_am_gain;
	logic [19:0] cfg_pm_index, cfg_fm_index;
	logic [31:0] carrier_acc, message_acc;
	logic signed [31:0] sine_quarter [0:QSIZE];

	logic pending_ticks[$];
	sample_t expected_samples[$];

	logic in_acc = 1'b0;
	bit send_gaps, recv_gaps;
	int long_stall_req;
	int fail_count = 0;
	int cycle_count = 0;

	always #1 clk = ~clk;

	// quarter-wave table: Horner in Q30, truncating shifts
	task automatic build_sine_table();
		longint unsigned z, z2, r, v;
		for (int k = 0; k <= QSIZE; k++) begin
			z  = longint'(k) << (30 - (TAB_BITS - 2));
			z2 = (z * z) >> 30;
			r  = POLY_C9;
			r  = POLY_C7 - ((z2 * r) >> 30);
			r  = POLY_C5 - ((z2 * r) >> 30);
			r  = POLY_C3 - ((z2 * r) >> 30);
			r  = POLY_C1 - ((z2 * r) >> 30);
			r  = (z * r) >> 30;
			v  = (r * AMP + (64'd1 << 29)) >> 30;
			if (v > AMP)
				v = AMP;
			sine_quarter[k] = 32'(v);
		end
	endtask

	function automatic logic signed [31:0] table_sine(input logic [31:0] ph);
		logic [TAB_BITS-1:0] idx;
		logic [1:0] quad;
		logic [TAB_BITS-3:0] k;
		logic signed [31:0] v;
		idx  = ph[31 -: TAB_BITS];
		quad = idx[TAB_BITS-1 -: 2];
		k    = idx[TAB_BITS-3:0];
		v    = quad[0] ? sine_quarter[QSIZE - k] : sine_quarter[k];
		return quad[1] ? -v : v;
	endfunction

	// magnitude to Q1.15, round half up, clamp, sign back
	function automatic logic signed [15:0] scale_q15(input logic signed [31:0] v);
		longint mag;
		mag = (v < 0) ? -longint'(v) : longint'(v);
		if (SMP_BITS >= 16)
			mag = (mag + ((longint'(1) << SHIFT_R) >>> 1)) >>> SHIFT_R;
		else
			mag = mag <<< SHIFT_L;
		if (mag > 32767)
			mag = 32767;
		return 16'((v < 0) ? -mag : mag);
	endfunction

	// one sample tick: result from current phases, then advance
	task automatic compute_sample(input logic clear_phase, output sample_t s);
		logic signed [15:0] msg, car;
		longint g, mi, ci, p, mag, idx, prod;
		logic [31:0] off, ph;
		if (clear_phase) begin
			carrier_acc = '0;
			message_acc = '0;
		end
		msg = scale_q15(table_sine(message_acc));
		s.message = msg;
		mi = longint'(msg);
		if (cfg_mode == nco_pkg::MODE_AM) begin
			car = scale_q15(table_sine(carrier_acc + nco_pkg::QUARTER_TURN));
			g = longint'(cfg_am_gain);
			ci = longint'(car);
			p = g * (mi + 32768) * ci;
			mag = (p < 0) ? -p : p;
			mag = (mag + (longint'(1) <<< 28)) >>> 29;
			if (mag > MOD_MAX)
				mag = MOD_MAX;
			s.modulated = 19'((p < 0) ? -mag : mag);
		end else if (cfg_mode == nco_pkg::MODE_PM || cfg_mode == nco_pkg::MODE_FM) begin
			idx = longint'((cfg_mode == nco_pkg::MODE_PM) ? cfg_pm_index : cfg_fm_index);
			prod = idx * mi;
			// offset in Q.31 turns, doubled to a 32-bit phase
			off = 32'(prod <<< 1);
			ph = carrier_acc + off + nco_pkg::QUARTER_TURN;
			s.modulated = 19'(scale_q15(table_sine(ph)));
		end else begin
			s.modulated = '0;
		end
		carrier_acc = carrier_acc + cfg_carrier_step;
		message_acc = message_acc + cfg_message_step;
	endtask

	// APB write: setup then access; shadow follows the register
	task automatic apb_write(input logic [nco_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			nco_pkg::REG_CARRIER_STEP: cfg_carrier_step = val;
			nco_pkg::REG_MESSAGE_STEP: cfg_message_step = val;
			nco_pkg::REG_MODE:         cfg_mode         = val[1:0];
			nco_pkg::REG_AM_GAIN:      cfg_am_gain      = val[15:0];
			nco_pkg::REG_PM_INDEX:     cfg_pm_index     = val[19:0];
			nco_pkg::REG_FM_INDEX:     cfg_fm_index     = val[19:0];
			default: ;
		endcase
	endtask

	// extremes, small steps or random, with stray upper bits at times
	function automatic logic [31:0] pick_setting(input int w);
		logic [31:0] mask, val;
		int r;
		mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
		r = $urandom_range(0, 9);
		if (r == 0)
			val = 32'd0;
		else if (r == 1)
			val = mask;
		else if (r == 2)
			val = $urandom_range(0, 32'h0100_0000) & mask;
		else
			val = $urandom() & mask;
		if ($urandom_range(0, 1))
			val = val | ($urandom() & ~mask);
		return val;
	endfunction

	task automatic random_settings();
		logic [31:0] val;
		int r;
		r = $urandom_range(0, 9);
		val = $urandom();
		if ($urandom_range(0, 1))
			val = '0;
		val[1:0] = (r < 3) ? nco_pkg::MODE_AM : (r < 6) ? nco_pkg::MODE_PM :
		           (r < 9) ? nco_pkg::MODE_FM : MODE_UNUSED;
		apb_write(nco_pkg::REG_MODE, val);
		apb_write(nco_pkg::REG_CARRIER_STEP, pick_setting(32));
		apb_write(nco_pkg::REG_MESSAGE_STEP, pick_setting(32));
		apb_write(nco_pkg::REG_AM_GAIN, pick_setting(16));
		apb_write(nco_pkg::REG_PM_INDEX, pick_setting(20));
		apb_write(nco_pkg::REG_FM_INDEX, pick_setting(20));
		if ($urandom_range(0, 3) == 0)
			apb_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
	endtask

	// all requests taken, all results back, pipeline settled
	task automatic wait_idle();
		while (pending_ticks.size() != 0 || in_valid || expected_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_acc) begin
			if (pending_ticks.size() == 0 ||
			    (send_gaps && $urandom_range(0, 99) < IDLE_PCT)) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				restart  <= pending_ticks.pop_front();
			end
		end
	end

	// result receiver, with a long hold-off on request
	int stall_left = 0;
	int stall_seen = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_seen != long_stall_req) begin
				stall_seen = long_stall_req;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(recv_gaps && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// predict on request, check on result
	always @(posedge clk) begin
		sample_t want, got;
		if (arst_n && in_valid && in_ready) begin
			compute_sample(restart, want);
			expected_samples.push_back(want);
		end
		in_acc <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			got.modulated = modulated;
			got.message   = message;
			if (expected_samples.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: modulated=%0d message=%0d",
					         got.modulated, got.message);
			end else begin
				want = expected_samples.pop_front();
				if (got.modulated !== want.modulated || got.message !== want.message) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: modulated exp %0d got %0d, message exp %0d got %0d",
						         want.modulated, got.modulated, want.message, got.message);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clk      = 1'b0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		restart  = 1'b0;
		out_ready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		long_stall_req = 0;
		build_sine_table();
		cfg_carrier_step = nco_pkg::CARRIER_STEP_RST;
		cfg_message_step = nco_pkg::MESSAGE_STEP_RST;
		cfg_mode         = nco_pkg::MODE_RST;
		cfg_am_gain      = nco_pkg::AM_GAIN_RST;
		cfg_pm_index     = nco_pkg::PM_INDEX_RST;
		cfg_fm_index     = nco_pkg::FM_INDEX_RST;
		carrier_acc      = '0;
		message_acc      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults, AM, restart mid-stream
		pending_ticks = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
		wait_idle();

		// quadrant boundaries on the carrier, full AM depth
		apb_write(nco_pkg::REG_CARRIER_STEP, 32'h4000_0000);
		apb_write(nco_pkg::REG_MESSAGE_STEP, 32'h0040_0000);
		apb_write(nco_pkg::REG_AM_GAIN, 32'h0000_FFFF);
		pending_ticks = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
		wait_idle();

		// PM with the largest index, steps at the top of the range
		apb_write(nco_pkg::REG_MODE, {30'd0, nco_pkg::MODE_PM});
		apb_write(nco_pkg::REG_PM_INDEX, 32'h000F_FFFF);
		apb_write(nco_pkg::REG_CARRIER_STEP, 32'hFFFF_FFFF);
		apb_write(nco_pkg::REG_MESSAGE_STEP, 32'h3FFF_FFFF);
		pending_ticks = '{1'b1, 1'b0, 1'b0, 1'b0};
		wait_idle();

		// FM with zero index and frozen phases
		apb_write(nco_pkg::REG_MODE, {30'd0, nco_pkg::MODE_FM});
		apb_write(nco_pkg::REG_FM_INDEX, 32'd0);
		apb_write(nco_pkg::REG_CARRIER_STEP, 32'd0);
		apb_write(nco_pkg::REG_MESSAGE_STEP, 32'd0);
		pending_ticks = '{1'b0, 1'b1, 1'b0};
		wait_idle();

		// unused mode; writes past the register map are dropped
		apb_write(nco_pkg::REG_MODE, {30'd0, MODE_UNUSED});
		apb_write(REG_SPARE_LO, 32'hFFFF_FFFF);
		apb_write(REG_SPARE_HI, 32'hFFFF_FFFF);
		apb_write(nco_pkg::REG_MESSAGE_STEP, 32'h0123_4567);
		pending_ticks = '{1'b1, 1'b0, 1'b0};
		wait_idle();

		// random settings, random restarts
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_settings();
			send_gaps = (ph != 3 && ph != 6);
			recv_gaps = (ph != 6);
			if (ph == 3)
				long_stall_req++;
			for (int i = 0; i < TICKS_PER_PHASE; i++)
				pending_ticks.push_back($urandom_range(0, 99) < 3);
			wait_idle();
		end

		if (fail_count == 0 && expected_samples.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
